FILE: src/bpe_pkg.sv
// Shared types, constants and the control store of the bi-phase packet encoder.
package bpe_pkg;

    localparam int unsigned StepW = 3;
    localparam int unsigned CntW  = 5;

    typedef logic [StepW-1:0] step_addr_t;
    typedef logic [CntW-1:0]  cnt_t;

    localparam step_addr_t STEP_WAIT   = 3'd0;
    localparam step_addr_t STEP_PRE    = 3'd1;
    localparam step_addr_t STEP_START  = 3'd2;
    localparam step_addr_t STEP_DATA   = 3'd3;
    localparam step_addr_t STEP_PARITY = 3'd4;
    localparam step_addr_t STEP_STOP   = 3'd5;

    localparam cnt_t PREAMBLE_MAX  = 5'd25;
    localparam cnt_t PREAMBLE_RST  = 5'd15;
    localparam cnt_t BITS_PER_BYTE = 5'd8;

    typedef enum logic [2:0] {
        SRC_PRE,
        SRC_ZERO,
        SRC_DATA,
        SRC_PARITY,
        SRC_ONE
    } cell_src_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_LOAD8,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_INPUT,
        BR_COUNT,
        BR_CHECK
    } branch_t;

    typedef struct packed {
        logic       emit;
        cell_src_t  src;
        cnt_op_t    cnt_op;
        branch_t    br;
        step_addr_t jump_addr;
        step_addr_t next_addr;
    } ucode_t;

    typedef struct packed {
        ucode_t word;
        logic   go;
        logic   in_fire;
    } bpe_ctrl_t;

    typedef struct packed {
        logic take_preamble;
        logic cnt_is_one;
        logic chk_pending;
        logic out_space;
    } bpe_status_t;

    function automatic ucode_t ucode_rom(input step_addr_t addr);
        ucode_t w;
        w = '{emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_HOLD, br: BR_INPUT,
              jump_addr: STEP_PRE, next_addr: STEP_START};
        case (addr)
            STEP_WAIT:   w = '{emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_HOLD, br: BR_INPUT,
                               jump_addr: STEP_PRE, next_addr: STEP_START};
            STEP_PRE:    w = '{emit: 1'b1, src: SRC_PRE, cnt_op: CNT_DEC, br: BR_COUNT,
                               jump_addr: STEP_PRE, next_addr: STEP_START};
            STEP_START:  w = '{emit: 1'b1, src: SRC_ZERO, cnt_op: CNT_LOAD8, br: BR_NEXT,
                               jump_addr: STEP_WAIT, next_addr: STEP_DATA};
            STEP_DATA:   w = '{emit: 1'b1, src: SRC_DATA, cnt_op: CNT_DEC, br: BR_COUNT,
                               jump_addr: STEP_DATA, next_addr: STEP_PARITY};
            STEP_PARITY: w = '{emit: 1'b1, src: SRC_PARITY, cnt_op: CNT_HOLD, br: BR_NEXT,
                               jump_addr: STEP_WAIT, next_addr: STEP_STOP};
            STEP_STOP:   w = '{emit: 1'b1, src: SRC_ONE, cnt_op: CNT_HOLD, br: BR_CHECK,
                               jump_addr: STEP_START, next_addr: STEP_WAIT};
            default:     w = '{emit: 1'b0, src: SRC_ZERO, cnt_op: CNT_HOLD, br: BR_INPUT,
                               jump_addr: STEP_PRE, next_addr: STEP_START};
        endcase
        return w;
    endfunction

endpackage

FILE: src/biphase_packet_encoder.sv
// Top level of the differential bi-phase packet encoder.
// Input channel (in_valid/in_ready): one packet byte per word with first and
// last marks. Output channel (out_valid/out_ready): one line cell per word,
// given as the levels of its two halves, with end-of-run and end-of-packet marks.
// Config channel (cfg_valid/cfg_ready, always ready): preamble_cells, the count
// of one-cells sent ahead of a first byte, clamped at 25.
// A byte is taken only while the sequencer sits on its wait step; it then runs
// 11 cells, plus the preamble when marked first and 11 checksum cells when
// marked last. The sequencer steps one control word per cycle while not stalled,
// so with the receiver ready one cell leaves per cycle; a plain byte is the wait
// step plus 11 cells, the first passing the step and then the output register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset sets preamble_cells to 15, line level low and checksum zero.
module biphase_packet_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] preamble_cells,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_of_packet,
    input  logic       last_of_packet,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       first_half_level,
    output logic       second_half_level,
    output logic       last_of_run,
    output logic       end_of_packet
);
    import bpe_pkg::*;

    bpe_ctrl_t   ctrl;
    bpe_status_t status;

    bpe_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    bpe_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .preamble_cells    (preamble_cells),
        .data_byte         (data_byte),
        .first_of_packet   (first_of_packet),
        .last_of_packet    (last_of_packet),
        .ctrl              (ctrl),
        .status            (status),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .first_half_level  (first_half_level),
        .second_half_level (second_half_level),
        .last_of_run       (last_of_run),
        .end_of_packet     (end_of_packet)
    );

endmodule

FILE: src/bpe_sequencer.sv
// Step counter, control store lookup and branch logic of the encoder.
module bpe_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpe_pkg::bpe_status_t status,
    output bpe_pkg::bpe_ctrl_t   ctrl
);
    import bpe_pkg::*;

    step_addr_t step_reg;
    step_addr_t step_next;
    ucode_t     word;
    step_addr_t branch_addr;
    logic       go;

    assign word     = ucode_rom(step_reg);
    assign go       = !word.emit || status.out_space;
    assign in_ready = (word.br == BR_INPUT);

    assign ctrl.word    = word;
    assign ctrl.go      = go;
    assign ctrl.in_fire = in_valid && in_ready;

    always_comb
    begin
        unique case (word.br)
            BR_NEXT:
            begin
                branch_addr = word.next_addr;
            end
            BR_INPUT:
            begin
                if (!in_valid)
                begin
                    branch_addr = step_reg;
                end
                else if (status.take_preamble)
                begin
                    branch_addr = word.jump_addr;
                end
                else
                begin
                    branch_addr = word.next_addr;
                end
            end
            BR_COUNT:
            begin
                branch_addr = status.cnt_is_one ? word.next_addr : word.jump_addr;
            end
            BR_CHECK:
            begin
                branch_addr = status.chk_pending ? word.jump_addr : word.next_addr;
            end
            default:
            begin
                branch_addr = word.next_addr;
            end
        endcase
    end

    always_comb
    begin
        step_next = go ? branch_addr : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_STOP)
        else $error("step counter left the program");

endmodule

FILE: src/bpe_datapath.sv
// Byte shifter, parity, level, checksum, counter and output register of the encoder.
module bpe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [4:0]           preamble_cells,
    input  logic [7:0]           data_byte,
    input  logic                 first_of_packet,
    input  logic                 last_of_packet,
    input  bpe_pkg::bpe_ctrl_t   ctrl,
    output bpe_pkg::bpe_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 first_half_level,
    output logic                 second_half_level,
    output logic                 last_of_run,
    output logic                 end_of_packet
);
    import bpe_pkg::*;

    cnt_t       cfg_reg,  cfg_next;
    cnt_t       cnt_reg,  cnt_next;
    logic       level_reg, level_next;
    logic [7:0] chk_reg,  chk_next;
    logic       pending_reg, pending_next;
    logic       phase_reg, phase_next;
    logic [7:0] byte_reg, byte_next;
    logic       par_reg,  par_next;
    logic       ovalid_reg, ovalid_next;
    logic       ofirst_reg, ofirst_next;
    logic       osecond_reg, osecond_next;
    logic       olast_reg, olast_next;
    logic       oend_reg, oend_next;

    cnt_t       pre_eff;
    logic       emit_fire;
    logic       cell_bit;
    logic       half_a;
    logic       half_b;

    assign cfg_ready = 1'b1;
    assign pre_eff   = (cfg_reg > PREAMBLE_MAX) ? PREAMBLE_MAX : cfg_reg;
    assign emit_fire = ctrl.go && ctrl.word.emit;

    assign status.take_preamble = first_of_packet && (cfg_reg != '0);
    assign status.cnt_is_one    = (cnt_reg == cnt_t'(1));
    assign status.chk_pending   = pending_reg;
    assign status.out_space     = !ovalid_reg || out_ready;

    always_comb
    begin
        unique case (ctrl.word.src)
            SRC_ZERO:   cell_bit = 1'b0;
            SRC_DATA:   cell_bit = byte_reg[0];
            SRC_PARITY: cell_bit = ~par_reg;
            SRC_ONE:    cell_bit = 1'b1;
            SRC_PRE:    cell_bit = 1'b1;
            default:    cell_bit = 1'b0;
        endcase
        if (ctrl.word.src == SRC_PRE)
        begin
            half_a = 1'b1;
            half_b = 1'b0;
        end
        else
        begin
            half_a = ~level_reg;
            half_b = half_a ^ cell_bit;
        end
    end

    always_comb
    begin
        cfg_next     = cfg_reg;
        cnt_next     = cnt_reg;
        level_next   = level_reg;
        chk_next     = chk_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        byte_next    = byte_reg;
        par_next     = par_reg;
        ovalid_next  = ovalid_reg;
        ofirst_next  = ofirst_reg;
        osecond_next = osecond_reg;
        olast_next   = olast_reg;
        oend_next    = oend_reg;

        if (cfg_valid && cfg_ready)
        begin
            cfg_next = preamble_cells;
        end

        if (ctrl.in_fire)
        begin
            byte_next    = data_byte;
            cnt_next     = pre_eff;
            chk_next     = (first_of_packet ? 8'h00 : chk_reg) ^ data_byte;
            pending_next = last_of_packet;
            phase_next   = 1'b0;
            if (first_of_packet)
            begin
                level_next = 1'b0;
            end
        end

        if (emit_fire)
        begin
            unique case (ctrl.word.cnt_op)
                CNT_LOAD8: cnt_next = BITS_PER_BYTE;
                CNT_DEC:   cnt_next = cnt_reg - cnt_t'(1);
                CNT_HOLD:  cnt_next = cnt_reg;
                default:   cnt_next = cnt_reg;
            endcase
            if (ctrl.word.src != SRC_PRE)
            begin
                level_next = half_b;
            end
            if (ctrl.word.src == SRC_ZERO)
            begin
                par_next = 1'b0;
            end
            if (ctrl.word.src == SRC_DATA)
            begin
                byte_next = {1'b0, byte_reg[7:1]};
                par_next  = par_reg ^ cell_bit;
            end
            if (ctrl.word.src == SRC_ONE && pending_reg)
            begin
                byte_next    = chk_reg;
                chk_next     = 8'h00;
                pending_next = 1'b0;
                phase_next   = 1'b1;
            end
            ovalid_next  = 1'b1;
            ofirst_next  = half_a;
            osecond_next = half_b;
            olast_next   = (ctrl.word.src == SRC_ONE) && !pending_reg;
            oend_next    = (ctrl.word.src == SRC_ONE) && phase_reg;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= PREAMBLE_RST;
            cnt_reg     <= '0;
            level_reg   <= 1'b0;
            chk_reg     <= 8'h00;
            pending_reg <= 1'b0;
            phase_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            cnt_reg     <= cnt_next;
            level_reg   <= level_next;
            chk_reg     <= chk_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        par_reg     <= par_next;
        ofirst_reg  <= ofirst_next;
        osecond_reg <= osecond_next;
        olast_reg   <= olast_next;
        oend_reg    <= oend_next;
    end

    assign out_valid         = ovalid_reg;
    assign first_half_level  = ofirst_reg;
    assign second_half_level = osecond_reg;
    assign last_of_run       = olast_reg;
    assign end_of_packet     = oend_reg;

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.word.br == BR_COUNT) |-> (cnt_reg != '0))
        else $error("cell counter empty inside a counted loop");

    a_chk_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && phase_reg))
        else $error("checksum pending while checksum byte in flight");

    a_eop_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oend_reg) |-> olast_reg)
        else $error("end of packet without end of run");

endmodule
